// ----- rtl/assert_macros.svh -----
// Assertion helpers for the SHA-1 engine checker.
// Every use samples on clk and is masked while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain concurrent property.
`define HSE_ASSERT(lbl, prop) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
else $error("sha1 port property failed");

// Condition in one cycle implies a consequence in the next.
`define HSE_ASSERT_NEXT(lbl, cond, conseq) \
`HSE_ASSERT(lbl, (cond) |=> (conseq))

`endif

// ----- rtl/sha1_pkg.sv -----
package sha1_pkg;

	// Input transaction: one message byte and/or the end-of-message mark.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       message_end;
	} msg_t;

	// Output transaction: one digest word.
	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        final_word;
	} dig_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic avail;
	} q_stat_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_PAD,
		BK_COMP,
		BK_FIN,
		BK_EMIT
	} bk_state_t;

	localparam int QDEPTH  = 4;	// power of two: pointers wrap naturally
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = QPTR_W + 1;

	localparam int BLK_BYTES = 64;
	localparam int FILL_W    = $clog2(BLK_BYTES);
	localparam int BLK_W     = BLK_BYTES * 8;
	localparam int ROUNDS    = 80;
	localparam int RND_W     = $clog2(ROUNDS);
	localparam int DIG_WORDS = 5;

	localparam logic [FILL_W-1:0] LEN_POS  = FILL_W'(56);
	localparam logic [FILL_W-1:0] FILL_TOP = FILL_W'(BLK_BYTES - 1);
	localparam logic [7:0]        PAD_MARK = 8'h80;
	localparam logic [3:0]        LEN_BYTES = 4'd8;
	localparam logic [2:0]        LAST_IDX  = 3'(DIG_WORDS - 1);

	localparam logic [31:0] SHA1_IV [DIG_WORDS] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	function automatic logic [31:0] sha1_k(input logic [RND_W-1:0] rnd);
		logic [31:0] k;
		if (rnd < RND_W'(20)) begin
			k = 32'h5A827999;
		end else if (rnd < RND_W'(40)) begin
			k = 32'h6ED9EBA1;
		end else if (rnd < RND_W'(60)) begin
			k = 32'h8F1BBCDC;
		end else begin
			k = 32'hCA62C1D6;
		end
		return k;
	endfunction

	function automatic logic [31:0] sha1_f(input logic [RND_W-1:0] rnd,
			input logic [31:0] b, input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (rnd < RND_W'(20)) begin
			f = (b & c) | (~b & d);
		end else if (rnd >= RND_W'(40) && rnd < RND_W'(60)) begin
			f = (b & c) | (b & d) | (c & d);
		end else begin
			f = b ^ c ^ d;
		end
		return f;
	endfunction

endpackage

// ----- rtl/sha1_front.sv -----
module sha1_front (
	input  logic              clk,
	input  logic              arst_n,
	input  sha1_pkg::msg_t    msg,
	input  logic              msg_valid,
	output logic              msg_stall,
	output logic              push,
	output sha1_pkg::msg_t    push_data,
	input  sha1_pkg::q_stat_t q_stat
);
	import sha1_pkg::*;

	logic item_vld_s1;
	msg_t item_s1;
	logic take;

	assign push      = item_vld_s1 && !q_stat.full;
	assign msg_stall = item_vld_s1 && q_stat.full;
	assign take      = msg_valid && !msg_stall;
	assign push_data = item_s1;

	// Drop transactions that carry neither a byte nor the end mark.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
		end else if (take) begin
			item_vld_s1 <= msg.byte_present || msg.message_end;
		end else if (push) begin
			item_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= msg;
		end
	end

endmodule

// ----- rtl/sha1_queue.sv -----
module sha1_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sha1_pkg::msg_t    push_data,
	input  logic              pop,
	output sha1_pkg::msg_t    head,
	output sha1_pkg::q_stat_t q_stat
);
	import sha1_pkg::*;

	msg_t              ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign q_stat.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign q_stat.avail = (cnt_q != '0);
	assign head         = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- rtl/sha1_core.sv -----
module sha1_core (
	input  logic              clk,
	input  logic              arst_n,
	input  sha1_pkg::msg_t    head,
	input  sha1_pkg::q_stat_t q_stat,
	output logic              pop,
	output sha1_pkg::dig_t    dig,
	output logic              dig_valid,
	input  logic              dig_stall
);
	import sha1_pkg::*;

	bk_state_t state_q, state_nx;

	logic [FILL_W-1:0] fill_q;
	logic [63:0]       bits_q;
	logic [63:0]       len_q;
	logic              pad_q;
	logic              mark_q;
	logic [3:0]        len_cnt_q;
	logic [RND_W-1:0]  rnd_q;
	logic [2:0]        idx_q;
	logic [31:0]       chain_q [DIG_WORDS];
	logic [31:0]       a_q, b_q, c_q, d_q, e_q;
	logic [BLK_W-1:0]  blk_q;

	logic        put_en;
	logic [7:0]  put_data;
	logic [7:0]  pad_data;
	logic        len_phase;
	logic        comp_start;
	logic        dig_take;
	logic [31:0] w0, w2, w8, w13, wx, w_new, t_sum;

	// Padding byte: the marker, zeros up to the length field, then the length.
	assign len_phase = mark_q && (len_cnt_q != '0 || fill_q == LEN_POS);
	always_comb begin
		if (!mark_q) begin
			pad_data = PAD_MARK;
		end else if (!len_phase) begin
			pad_data = 8'h00;
		end else begin
			pad_data = len_q[63:56];
		end
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			BK_IDLE: begin
				if (q_stat.avail) begin
					if (head.byte_present && fill_q == FILL_TOP) begin
						state_nx = BK_COMP;
					end else if (head.message_end) begin
						state_nx = BK_PAD;
					end
				end
			end
			BK_PAD: begin
				if (fill_q == FILL_TOP) begin
					state_nx = BK_COMP;
				end
			end
			BK_COMP: begin
				if (rnd_q == RND_W'(ROUNDS - 1)) begin
					state_nx = BK_FIN;
				end
			end
			BK_FIN: begin
				if (pad_q && len_cnt_q == LEN_BYTES) begin
					state_nx = BK_EMIT;
				end else if (pad_q) begin
					state_nx = BK_PAD;
				end else begin
					state_nx = BK_IDLE;
				end
			end
			BK_EMIT: begin
				if (!dig_stall && idx_q == LAST_IDX) begin
					state_nx = BK_IDLE;
				end
			end
			default: state_nx = BK_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		pop       = 1'b0;
		put_en    = 1'b0;
		put_data  = head.data_byte;
		dig_valid = 1'b0;
		case (state_q)
			BK_IDLE: begin
				pop    = q_stat.avail;
				put_en = q_stat.avail && head.byte_present;
			end
			BK_PAD: begin
				put_en   = 1'b1;
				put_data = pad_data;
			end
			BK_EMIT: dig_valid = 1'b1;
			default: ;
		endcase
	end

	assign comp_start = (state_nx == BK_COMP) && (state_q != BK_COMP);
	assign dig_take   = dig_valid && !dig_stall;

	assign dig.digest_word = chain_q[0];
	assign dig.word_index  = idx_q;
	assign dig.final_word  = (idx_q == LAST_IDX);

	// Message schedule taps on the 16-word window; the oldest word sits on top.
	assign w0    = blk_q[BLK_W-1 -: 32];
	assign w2    = blk_q[BLK_W-1-2*32 -: 32];
	assign w8    = blk_q[BLK_W-1-8*32 -: 32];
	assign w13   = blk_q[BLK_W-1-13*32 -: 32];
	assign wx    = w13 ^ w8 ^ w2 ^ w0;
	assign w_new = {wx[30:0], wx[31]};
	assign t_sum = {a_q[26:0], a_q[31:27]} + sha1_f(rnd_q, b_q, c_q, d_q) + e_q
		+ sha1_k(rnd_q) + w0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			fill_q    <= '0;
			bits_q    <= '0;
			pad_q     <= 1'b0;
			mark_q    <= 1'b0;
			len_cnt_q <= '0;
			rnd_q     <= '0;
			idx_q     <= '0;
			for (int i = 0; i < DIG_WORDS; i++) begin
				chain_q[i] <= SHA1_IV[i];
			end
		end else begin
			state_q <= state_nx;
			if (put_en) begin
				fill_q <= fill_q + FILL_W'(1);
			end
			if (pop) begin
				if (head.byte_present) begin
					bits_q <= bits_q + 64'd8;
				end
				if (head.message_end) begin
					pad_q     <= 1'b1;
					mark_q    <= 1'b0;
					len_cnt_q <= '0;
				end
			end
			if (state_q == BK_PAD) begin
				if (!mark_q) begin
					mark_q <= 1'b1;
				end else if (len_phase) begin
					len_cnt_q <= len_cnt_q + 4'd1;
				end
			end
			if (comp_start) begin
				rnd_q <= '0;
			end else if (state_q == BK_COMP) begin
				rnd_q <= rnd_q + RND_W'(1);
			end
			if (state_q == BK_FIN) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
			end
			// Drain the digest from word 0, then restore the initial value.
			if (dig_take) begin
				if (idx_q == LAST_IDX) begin
					idx_q  <= '0;
					bits_q <= '0;
					pad_q  <= 1'b0;
					mark_q <= 1'b0;
					len_cnt_q <= '0;
					for (int i = 0; i < DIG_WORDS; i++) begin
						chain_q[i] <= SHA1_IV[i];
					end
				end else begin
					idx_q <= idx_q + 3'd1;
					for (int i = 0; i < DIG_WORDS - 1; i++) begin
						chain_q[i] <= chain_q[i+1];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (put_en) begin
			blk_q <= {blk_q[BLK_W-9:0], put_data};
		end else if (state_q == BK_COMP) begin
			blk_q <= {blk_q[BLK_W-33:0], w_new};
		end
		if (pop && head.message_end) begin
			len_q <= head.byte_present ? bits_q + 64'd8 : bits_q;
		end else if (state_q == BK_PAD && len_phase) begin
			len_q <= {len_q[55:0], 8'h00};
		end
		if (comp_start) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (state_q == BK_COMP) begin
			a_q <= t_sum;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

endmodule

// ----- rtl/sha1_hash_engine_top.sv -----
// SHA-1 hash engine: one message byte per input transaction, digest out as five words.
// Throughput: one byte per cycle into the block buffer while the queue holds bytes, then
// the 80 rounds and the chaining add per 64-byte block.
// After the end mark is accepted: the padding bytes, the final block or blocks compressed,
// then the digest words out from word 0.
// Reset (arst_n low, async): queue empty, chaining value at the SHA-1 initial value.
module sha1_hash_engine_top (
	input  logic           clk,
	input  logic           arst_n,
	input  sha1_pkg::msg_t msg,
	input  logic           msg_valid,
	output logic           msg_stall,
	output sha1_pkg::dig_t dig,
	output logic           dig_valid,
	input  logic           dig_stall
);
	import sha1_pkg::*;

	// Front: take a transaction, drop ones with no byte and no end mark.
	msg_t    push_data;
	logic    push;
	// Queue between front and back lets the input keep flowing during rounds.
	q_stat_t q_stat;
	msg_t    head;
	logic    pop;

	sha1_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg       (msg),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.push      (push),
		.push_data (push_data),
		.q_stat    (q_stat)
	);

	sha1_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	// Back: fill the block, pad at the end mark, run rounds, drain the digest.
	sha1_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.dig       (dig),
		.dig_valid (dig_valid),
		.dig_stall (dig_stall)
	);

endmodule

// ----- rtl/sha1_chk.sv -----
`include "assert_macros.svh"

module sha1_chk (
	input logic           clk,
	input logic           arst_n,
	input sha1_pkg::msg_t msg,
	input logic           msg_valid,
	input logic           msg_stall,
	input sha1_pkg::dig_t dig,
	input logic           dig_valid,
	input logic           dig_stall
);
	import sha1_pkg::*;

	`HSE_ASSERT_NEXT(a_dig_hold, dig_valid && dig_stall, dig_valid && $stable(dig))
	`HSE_ASSERT(a_final_idx, dig_valid |-> (dig.final_word == (dig.word_index == LAST_IDX)))
	`HSE_ASSERT_NEXT(a_idx_step, dig_valid && !dig_stall && !dig.final_word, dig_valid && dig.word_index == $past(dig.word_index) + 3'd1)
	`HSE_ASSERT_NEXT(a_msg_gap, dig_valid && !dig_stall && dig.final_word, !dig_valid)
	`HSE_ASSERT(a_in_known, msg_valid && !msg_stall |-> !$isunknown(msg.message_end))

endmodule

bind sha1_hash_engine_top sha1_chk u_chk (.*);

// ----- sim/sha1_digest_checker.sv -----
module sha1_digest_checker
	import sha1_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  msg_t msg,
	input  logic msg_valid,
	input  logic msg_stall,
	input  dig_t dig,
	input  logic dig_valid,
	input  logic dig_stall,
	output int   pending,
	output int   fails
);

	localparam logic [31:0] K_CH  = 32'h5A827999;
	localparam logic [31:0] K_PAR = 32'h6ED9EBA1;
	localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
	localparam logic [31:0] K_TOP = 32'hCA62C1D6;
	localparam logic [31:0] START_WORDS [5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};
	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam logic [6:0] LEN_OFFSET = 7'd56;
	localparam logic [6:0] BLOCK_SIZE = 7'd64;

	logic [31:0] chain [5];
	logic [7:0]  block_bytes [64];
	logic [6:0]  block_fill;
	logic [63:0] message_bits;
	dig_t        digest_words_due [$];
	dig_t        want;

	initial fails = 0;

	task automatic flag(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		fails++;
	endtask

	function automatic void restart_chain();
		for (int i = 0; i < 5; i++)
			chain[i] = START_WORDS[i];
		block_fill   = '0;
		message_bits = '0;
	endfunction

	// 80 rounds over the buffered block, then fold into the chaining value.
	function automatic void compress_block();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int r = 0; r < 16; r++)
			w[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2],
				block_bytes[4*r+3]};
		for (int r = 16; r < 80; r++) begin
			t = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
			w[r] = {t[30:0], t[31]};
		end
		a = chain[0];
		b = chain[1];
		c = chain[2];
		d = chain[3];
		e = chain[4];
		for (int r = 0; r < 80; r++) begin
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = K_CH;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = K_PAR;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K_MAJ;
			end else begin
				f = b ^ c ^ d;
				k = K_TOP;
			end
			t = {a[26:0], a[31:27]} + f + e + k + w[r];
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = t;
		end
		chain[0] += a;
		chain[1] += b;
		chain[2] += c;
		chain[3] += d;
		chain[4] += e;
	endfunction

	function automatic void absorb_byte(input logic [7:0] v);
		block_bytes[block_fill[5:0]] = v;
		block_fill++;
		if (block_fill == BLOCK_SIZE) begin
			compress_block();
			block_fill = '0;
		end
	endfunction

	// Pad, append the bit length, queue the five digest words, start over.
	function automatic void close_message();
		logic [63:0] len_bits;
		dig_t        w;
		len_bits = message_bits;
		absorb_byte(PAD_BYTE);
		while (block_fill != LEN_OFFSET)
			absorb_byte(8'h00);
		for (int i = 7; i >= 0; i--)
			absorb_byte(len_bits[8*i +: 8]);
		for (int i = 0; i < 5; i++) begin
			w.digest_word = chain[i];
			w.word_index  = 3'(i);
			w.final_word  = (i == 4);
			digest_words_due.push_back(w);
		end
		restart_chain();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_chain();
			digest_words_due.delete();
			pending <= 0;
		end else begin
			if (msg_valid && !msg_stall) begin
				if (msg.byte_present) begin
					message_bits += 64'd8;
					absorb_byte(msg.data_byte);
				end
				if (msg.message_end)
					close_message();
			end
			if (dig_valid && !dig_stall) begin
				if (digest_words_due.size() == 0) begin
					flag($sformatf("unexpected digest word %h index %0d",
						dig.digest_word, dig.word_index));
				end else begin
					want = digest_words_due.pop_front();
					if (dig.digest_word !== want.digest_word)
						flag($sformatf("digest_word got %h, expected %h",
							dig.digest_word, want.digest_word));
					if (dig.word_index !== want.word_index)
						flag($sformatf("word_index got %0d, expected %0d",
							dig.word_index, want.word_index));
					if (dig.final_word !== want.final_word)
						flag($sformatf("final_word got %b, expected %b",
							dig.final_word, want.final_word));
				end
			end
			pending <= digest_words_due.size();
		end
	end

endmodule

// ----- sim/tb_sha1_hash_engine_top.sv -----
module tb_sha1_hash_engine_top;
	import sha1_pkg::*;

	// Random part: four traffic phases, each about this many counted transactions.
	localparam int PHASE_ITEMS = 66;
	// Idle and stall odds per phase, percent: none, sender, receiver, both.
	localparam int SEND_IDLE [4] = '{0, 54, 0, 16};
	localparam int RECV_STALL [4] = '{0, 0, 54, 16};
	// Message lengths on either side of the one/two final block boundaries.
	localparam int EDGE_LENS [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
	// Wait used after the last digest has been taken, before the final verdict.
	localparam int TAIL_CYCLES = 300;
	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	msg_t msg = '0;
	logic msg_valid = 1'b0;
	logic msg_stall;
	dig_t dig;
	logic dig_valid;
	logic dig_stall = 1'b0;

	int pending;
	int fails;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int items_sent = 0;
	int cycle_count = 0;

	always #6 clk = ~clk;

	sha1_hash_engine_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg       (msg),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.dig       (dig),
		.dig_valid (dig_valid),
		.dig_stall (dig_stall)
	);

	sha1_digest_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg       (msg),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.dig       (dig),
		.dig_valid (dig_valid),
		.dig_stall (dig_stall),
		.pending   (pending),
		.fails     (fails)
	);

	// Receiver side: stall the digest channel at the odds of the current phase.
	always @(posedge clk) begin
		dig_stall <= ($urandom_range(99) < stall_pct);
	end

	// Watchdog: abort a run that hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Offer one transaction: idle at random first, then hold it until accepted.
	// Returns at the edge that accepted it, so the next call drives the following step.
	task automatic push_msg(input msg_t m);
		while ($urandom_range(99) < send_idle_pct) begin
			msg_valid <= 1'b0;
			@(posedge clk);
		end
		msg       <= m;
		msg_valid <= 1'b1;
		@(posedge clk);
		while (msg_stall)
			@(posedge clk);
	endtask

	// Drop valid and hold off until every digest word owed has been taken.
	// The checker's count is registered, so the loop waits on an edge before looking.
	task automatic drain_results();
		msg_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	// One whole message of random bytes. The last byte carries the end mark half the
	// time; otherwise a separate end transaction with a junk data byte closes it.
	// Ignored transactions (no byte, no end) are sprinkled in as noise.
	task automatic send_message(input int len);
		msg_t m;
		logic end_on_byte;
		end_on_byte = (len > 0) && ($urandom_range(1) == 1);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(9) == 0) begin
				m = '{data_byte: 8'($urandom_range(255)), byte_present: 1'b0,
					message_end: 1'b0};
				push_msg(m);
			end
			m = '{data_byte: 8'($urandom_range(255)), byte_present: 1'b1,
				message_end: end_on_byte && (i == len - 1)};
			push_msg(m);
			items_sent++;
		end
		if (!end_on_byte) begin
			m = '{data_byte: 8'($urandom_range(255)), byte_present: 1'b0,
				message_end: 1'b1};
			push_msg(m);
			items_sent++;
		end
	endtask

	initial begin
		int len;
		int phase_stop;
		int pick;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty message right out of reset.
		push_msg('{data_byte: 8'h00, byte_present: 1'b0, message_end: 1'b1});
		// Single byte arriving together with the end mark, both data extremes.
		push_msg('{data_byte: 8'h00, byte_present: 1'b1, message_end: 1'b1});
		push_msg('{data_byte: 8'hFF, byte_present: 1'b1, message_end: 1'b1});
		// Ignored transaction between messages.
		push_msg('{data_byte: 8'hA5, byte_present: 1'b0, message_end: 1'b0});
		// "abc", closed by an end transaction that carries no byte.
		push_msg('{data_byte: 8'h61, byte_present: 1'b1, message_end: 1'b0});
		push_msg('{data_byte: 8'h62, byte_present: 1'b1, message_end: 1'b0});
		push_msg('{data_byte: 8'h63, byte_present: 1'b1, message_end: 1'b0});
		push_msg('{data_byte: 8'hFF, byte_present: 1'b0, message_end: 1'b1});
		// Ignored transaction in the middle of a message.
		push_msg('{data_byte: 8'h5A, byte_present: 1'b1, message_end: 1'b0});
		push_msg('{data_byte: 8'hFF, byte_present: 1'b0, message_end: 1'b0});
		push_msg('{data_byte: 8'hC3, byte_present: 1'b1, message_end: 1'b1});
		// Empty message straight after another digest.
		push_msg('{data_byte: 8'h3C, byte_present: 1'b0, message_end: 1'b1});
		items_sent = 10;
		drain_results();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = SEND_IDLE[ph];
			stall_pct    <= RECV_STALL[ph];
			phase_stop    = items_sent + PHASE_ITEMS;
			while (items_sent < phase_stop) begin
				// Mostly short messages, with boundary lengths and the odd long one.
				pick = $urandom_range(99);
				if (pick < 45)
					len = $urandom_range(6);
				else if (pick < 65)
					len = EDGE_LENS[$urandom_range(7)];
				else if (pick < 85)
					len = $urandom_range(40, 7);
				else
					len = $urandom_range(130, 41);
				send_message(len);
			end
			// Pause the sender until every digest word of this phase is out.
			drain_results();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
